// ===== rtl/ilt_pkg.sv =====
package ilt_pkg;

  localparam int NAME_BYTES  = 32;
  localparam int VALUE_BYTES = 32;

  localparam int LEN_W       = 5;
  localparam int STORE_BYTES = 32;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BYTE_SEL_W  = 3;
  localparam int WORD_BYTES  = 8;
  localparam int WORD_W      = 64;
  localparam int STORE_WORDS = STORE_BYTES / WORD_BYTES;
  localparam int WIDX_W      = $clog2(STORE_WORDS);
  localparam int WCNT_W      = WIDX_W + 1;
  localparam int LINE_W      = 20;
  localparam int CHAR_W      = 8;

  localparam logic [LEN_W-1:0] NAME_CAP =
      LEN_W'(((NAME_BYTES < 32) ? NAME_BYTES : 32) - 1);
  localparam logic [LEN_W-1:0] VALUE_CAP =
      LEN_W'(((VALUE_BYTES < 32) ? VALUE_BYTES : 32) - 1);
  localparam logic [LINE_W-1:0] LINE_MAX   = '1;
  localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DIG0   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG9   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [2:0] {
    PH_LINE, PH_SECTION, PH_PARAM, PH_VALUE,
    PH_SEEK_P, PH_SEEK_V, PH_SEEK_S, PH_COMMENT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SECTION, KIND_PARAM, KIND_ERROR, KIND_DONE
  } kind_e;

  typedef enum logic [2:0] {
    ERR_BAD_NAME, ERR_BAD_SECTION, ERR_BAD_VALUE, ERR_SECTION_OVF,
    ERR_NAME_OVF, ERR_VALUE_OVF, ERR_NO_EQUALS, ERR_UNFINISHED
  } err_e;

  typedef struct packed {
    kind_e               kind;
    logic                bank;
    logic                with_done;
    logic [LEN_W-1:0]    name_len;
    logic [LEN_W-1:0]    value_len;
    logic [LINE_W-1:0]   line;
    err_e                code;
    logic [CHAR_W-1:0]   bad_byte;
  } job_t;

  typedef struct packed {
    logic                en;
    logic                bank;
    logic                part;
    logic [ADDR_W-1:0]   addr;
    logic [CHAR_W-1:0]   data;
  } store_wr_t;

  typedef struct packed {
    logic                bank;
    logic                part;
    logic [WIDX_W-1:0]   word;
  } store_rd_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  function automatic logic is_name_char(logic [CHAR_W-1:0] c);
    return (c >= CH_DIG0 && c <= CH_DIG9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_LO_A && c <= CH_LO_Z) || (c == CH_USCORE);
  endfunction

  function automatic logic is_value_char(logic [CHAR_W-1:0] c);
    return (c >= CH_BANG) && (c <= CH_TILDE) && (c != CH_SEMI) && (c != CH_HASH);
  endfunction

  // Words needed for a buffer of len bytes; an empty buffer still takes one.
  function automatic logic [WCNT_W-1:0] word_count(logic [LEN_W-1:0] len);
    logic [LEN_W:0] sum;
    sum = {1'b0, len} + (LEN_W + 1)'(WORD_BYTES - 1);
    if (len == '0) begin
      return WCNT_W'(1);
    end
    return WCNT_W'(sum >> BYTE_SEL_W);
  endfunction

endpackage

// ===== rtl/ilt_store.sv =====
module ilt_store (
  input  logic                         clk_i,
  input  ilt_pkg::store_wr_t           wr_i,
  input  ilt_pkg::store_rd_t           rd_i,
  output logic [ilt_pkg::WORD_W-1:0]   rd_data_o
);

  // Two banks, each with a name part and a value part, kept as 64-bit words.
  logic [ilt_pkg::WORD_W-1:0] words_q [2][2][ilt_pkg::STORE_WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      words_q[wr_i.bank][wr_i.part][wr_i.addr[ilt_pkg::ADDR_W-1:ilt_pkg::BYTE_SEL_W]]
          [wr_i.addr[ilt_pkg::BYTE_SEL_W-1:0]*ilt_pkg::CHAR_W +: ilt_pkg::CHAR_W]
          <= wr_i.data;
    end
  end

  assign rd_data_o = words_q[rd_i.bank][rd_i.part][rd_i.word];

endmodule

// ===== rtl/ilt_queue.sv =====
module ilt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ilt_pkg::job_t  job_i,
  input  logic           pop_i,
  output ilt_pkg::job_t  job_o,
  output logic           full_o,
  output logic           empty_o
);

  ilt_pkg::job_t                  entries_q [ilt_pkg::QUEUE_DEPTH];
  logic [ilt_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ilt_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ilt_pkg::QCNT_W-1:0]     count_q, count_d;

  function automatic logic [ilt_pkg::QPTR_W-1:0] bump(logic [ilt_pkg::QPTR_W-1:0] p);
    if (p == ilt_pkg::QPTR_W'(ilt_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ilt_pkg::QPTR_W'(1);
  endfunction

  assign full_o  = (count_q == ilt_pkg::QCNT_W'(ilt_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + ilt_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - ilt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/ilt_front.sv =====
module ilt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ilt_pkg::CHAR_W-1:0]    char_byte_i,
  input  logic                          end_of_input_i,
  output logic                          in_stall_o,
  input  logic                          q_full_i,
  output logic                          push_o,
  output ilt_pkg::job_t                 job_o,
  output ilt_pkg::store_wr_t            wr_o,
  input  ilt_pkg::release_t             rel_i
);

  ilt_pkg::phase_e              phase_q, phase_d;
  logic                         halted_q, halted_d;
  logic [ilt_pkg::LEN_W-1:0]    nc_q, nc_d;
  logic [ilt_pkg::LEN_W-1:0]    vc_q, vc_d;
  logic [ilt_pkg::LINE_W-1:0]   line_q, line_d;
  logic                         wb_q, wb_d;
  logic [1:0]                   busy_q, busy_d;

  logic                         accept;
  logic                         is_nl, is_sp, is_cmt, name_c, value_c;
  logic [ilt_pkg::LEN_W-1:0]    name_base;

  // Decoded action for the item at the input.
  ilt_pkg::phase_e              dec_phase;
  logic                         dec_fail;
  logic                         dec_job;
  logic                         dec_emit;
  logic                         dec_with_done;
  ilt_pkg::kind_e               dec_kind;
  ilt_pkg::err_e                dec_code;
  logic [ilt_pkg::CHAR_W-1:0]   dec_byte;
  logic                         dec_name_wr, dec_name_first, dec_name_clr;
  logic                         dec_value_wr, dec_value_clr;

  // The bank being filled must not still be read by the back end.
  assign in_stall_o = q_full_i || busy_q[wb_q];
  assign accept     = in_valid_i && !in_stall_o;

  assign is_nl   = (char_byte_i == ilt_pkg::CH_NL);
  assign is_sp   = (char_byte_i == ilt_pkg::CH_SPACE);
  assign is_cmt  = (char_byte_i == ilt_pkg::CH_SEMI) || (char_byte_i == ilt_pkg::CH_HASH);
  assign name_c  = ilt_pkg::is_name_char(char_byte_i);
  assign value_c = ilt_pkg::is_value_char(char_byte_i);
  assign name_base = dec_name_first ? '0 : nc_q;

  always_comb begin
    dec_phase      = phase_q;
    dec_fail       = 1'b0;
    dec_job        = 1'b0;
    dec_emit       = 1'b0;
    dec_with_done  = 1'b0;
    dec_kind       = ilt_pkg::KIND_DONE;
    dec_code       = ilt_pkg::ERR_BAD_NAME;
    dec_byte       = char_byte_i;
    dec_name_wr    = 1'b0;
    dec_name_first = 1'b0;
    dec_name_clr   = 1'b0;
    dec_value_wr   = 1'b0;
    dec_value_clr  = 1'b0;
    if (end_of_input_i) begin
      dec_byte = '0;
      if (!halted_q) begin
        dec_job = 1'b1;
        unique case (phase_q)
          ilt_pkg::PH_SEEK_S: begin
            dec_emit      = 1'b1;
            dec_kind      = ilt_pkg::KIND_SECTION;
            dec_with_done = 1'b1;
          end
          ilt_pkg::PH_SEEK_V: begin
            dec_emit      = 1'b1;
            dec_kind      = ilt_pkg::KIND_PARAM;
            dec_with_done = 1'b1;
          end
          ilt_pkg::PH_VALUE: begin
            if (vc_q == '0) begin
              dec_kind = ilt_pkg::KIND_ERROR;
              dec_code = ilt_pkg::ERR_BAD_VALUE;
            end else begin
              dec_emit      = 1'b1;
              dec_kind      = ilt_pkg::KIND_PARAM;
              dec_with_done = 1'b1;
            end
          end
          ilt_pkg::PH_SECTION, ilt_pkg::PH_PARAM, ilt_pkg::PH_SEEK_P: begin
            dec_kind = ilt_pkg::KIND_ERROR;
            dec_code = ilt_pkg::ERR_UNFINISHED;
          end
          default: begin
            dec_kind = ilt_pkg::KIND_DONE;
          end
        endcase
      end
    end else if (!halted_q) begin
      unique case (phase_q)
        ilt_pkg::PH_LINE: begin
          if (name_c) begin
            dec_name_wr    = 1'b1;
            dec_name_first = 1'b1;
            dec_phase      = ilt_pkg::PH_PARAM;
          end else if (char_byte_i == ilt_pkg::CH_LBRACK) begin
            dec_name_clr = 1'b1;
            dec_phase    = ilt_pkg::PH_SECTION;
          end else if (is_cmt) begin
            dec_phase = ilt_pkg::PH_COMMENT;
          end else if (!is_nl && !is_sp) begin
            dec_fail = 1'b1;
            dec_code = ilt_pkg::ERR_BAD_NAME;
          end
        end
        ilt_pkg::PH_SECTION, ilt_pkg::PH_PARAM: begin
          if (name_c) begin
            if (nc_q >= ilt_pkg::NAME_CAP) begin
              dec_fail = 1'b1;
              dec_code = (phase_q == ilt_pkg::PH_SECTION) ? ilt_pkg::ERR_SECTION_OVF
                                                          : ilt_pkg::ERR_NAME_OVF;
            end else begin
              dec_name_wr = 1'b1;
            end
          end else if (phase_q == ilt_pkg::PH_SECTION && char_byte_i == ilt_pkg::CH_RBRACK) begin
            dec_phase = ilt_pkg::PH_SEEK_S;
          end else if (phase_q == ilt_pkg::PH_PARAM && char_byte_i == ilt_pkg::CH_EQUALS) begin
            dec_value_clr = 1'b1;
            dec_phase     = ilt_pkg::PH_VALUE;
          end else if (phase_q == ilt_pkg::PH_PARAM && is_sp) begin
            dec_phase = ilt_pkg::PH_SEEK_P;
          end else begin
            dec_fail = 1'b1;
            dec_code = (phase_q == ilt_pkg::PH_SECTION) ? ilt_pkg::ERR_BAD_SECTION
                                                        : ilt_pkg::ERR_BAD_NAME;
          end
        end
        ilt_pkg::PH_VALUE: begin
          if (value_c) begin
            if (vc_q >= ilt_pkg::VALUE_CAP) begin
              dec_fail = 1'b1;
              dec_code = ilt_pkg::ERR_VALUE_OVF;
            end else begin
              dec_value_wr = 1'b1;
            end
          end else if (is_sp && vc_q == '0) begin
            dec_phase = ilt_pkg::PH_VALUE;
          end else if ((is_nl || is_cmt) && vc_q != '0) begin
            dec_job   = 1'b1;
            dec_emit  = 1'b1;
            dec_kind  = ilt_pkg::KIND_PARAM;
            dec_phase = is_nl ? ilt_pkg::PH_LINE : ilt_pkg::PH_COMMENT;
          end else if (is_sp) begin
            dec_phase = ilt_pkg::PH_SEEK_V;
          end else begin
            dec_fail = 1'b1;
            dec_code = ilt_pkg::ERR_BAD_VALUE;
          end
        end
        ilt_pkg::PH_SEEK_P: begin
          if (char_byte_i == ilt_pkg::CH_EQUALS) begin
            dec_value_clr = 1'b1;
            dec_phase     = ilt_pkg::PH_VALUE;
          end else if (!is_sp) begin
            dec_fail = 1'b1;
            dec_code = ilt_pkg::ERR_NO_EQUALS;
          end
        end
        ilt_pkg::PH_SEEK_V, ilt_pkg::PH_SEEK_S: begin
          if (is_nl || is_cmt) begin
            dec_job   = 1'b1;
            dec_emit  = 1'b1;
            dec_kind  = (phase_q == ilt_pkg::PH_SEEK_S) ? ilt_pkg::KIND_SECTION
                                                        : ilt_pkg::KIND_PARAM;
            dec_phase = is_nl ? ilt_pkg::PH_LINE : ilt_pkg::PH_COMMENT;
          end else if (!is_sp) begin
            dec_fail = 1'b1;
            dec_code = (phase_q == ilt_pkg::PH_SEEK_S) ? ilt_pkg::ERR_BAD_SECTION
                                                       : ilt_pkg::ERR_BAD_VALUE;
          end
        end
        default: begin
          if (is_nl) begin
            dec_phase = ilt_pkg::PH_LINE;
          end
        end
      endcase
      if (dec_fail) begin
        dec_job  = 1'b1;
        dec_kind = ilt_pkg::KIND_ERROR;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    halted_d = halted_q;
    nc_d     = nc_q;
    vc_d     = vc_q;
    line_d   = line_q;
    wb_d     = wb_q;
    busy_d   = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (dec_emit) begin
        busy_d[wb_q] = 1'b1;
        wb_d         = ~wb_q;
      end
      if (end_of_input_i) begin
        phase_d  = ilt_pkg::PH_LINE;
        halted_d = 1'b0;
        nc_d     = '0;
        vc_d     = '0;
        line_d   = ilt_pkg::LINE_FIRST;
      end else if (!halted_q) begin
        if (dec_fail) begin
          halted_d = 1'b1;
        end else begin
          phase_d = dec_phase;
          if (dec_name_clr) begin
            nc_d = '0;
          end else if (dec_name_wr) begin
            nc_d = name_base + ilt_pkg::LEN_W'(1);
          end
          if (dec_value_clr) begin
            vc_d = '0;
          end else if (dec_value_wr) begin
            vc_d = vc_q + ilt_pkg::LEN_W'(1);
          end
          if (is_nl && line_q != ilt_pkg::LINE_MAX) begin
            line_d = line_q + ilt_pkg::LINE_W'(1);
          end
        end
      end
    end
  end

  // Outputs toward the queue and the byte stores.
  always_comb begin
    push_o          = accept && dec_job;
    job_o.kind      = dec_kind;
    job_o.bank      = wb_q;
    job_o.with_done = dec_with_done;
    job_o.name_len  = nc_q;
    job_o.value_len = (dec_kind == ilt_pkg::KIND_PARAM) ? vc_q : '0;
    job_o.line      = line_q;
    job_o.code      = dec_code;
    job_o.bad_byte  = dec_byte;

    wr_o.en   = accept && !end_of_input_i && !dec_fail && (dec_name_wr || dec_value_wr);
    wr_o.bank = wb_q;
    wr_o.part = dec_value_wr;
    wr_o.addr = dec_value_wr ? vc_q : name_base;
    wr_o.data = char_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ilt_pkg::PH_LINE;
      halted_q <= 1'b0;
      nc_q     <= '0;
      vc_q     <= '0;
      line_q   <= ilt_pkg::LINE_FIRST;
      wb_q     <= 1'b0;
      busy_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      halted_q <= halted_d;
      nc_q     <= nc_d;
      vc_q     <= vc_d;
      line_q   <= line_d;
      wb_q     <= wb_d;
      busy_q   <= busy_d;
    end
  end

endmodule

// ===== rtl/ilt_back.sv =====
module ilt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ilt_pkg::job_t                 job_i,
  input  logic                          q_empty_i,
  output logic                          pop_o,
  output ilt_pkg::release_t             rel_o,
  output ilt_pkg::store_rd_t            rd_o,
  input  logic [ilt_pkg::WORD_W-1:0]    rd_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic                          part_o,
  output logic [ilt_pkg::WIDX_W-1:0]    word_index_o,
  output logic [ilt_pkg::WORD_W-1:0]    data_word_o,
  output logic [ilt_pkg::LEN_W-1:0]     name_length_o,
  output logic [ilt_pkg::LEN_W-1:0]     value_length_o,
  output logic [ilt_pkg::LINE_W-1:0]    line_number_o,
  output logic [2:0]                    error_code_o,
  output logic                          last_o
);

  logic                          part_q, part_d;
  logic [ilt_pkg::WIDX_W-1:0]    widx_q, widx_d;
  logic                          tail_q, tail_d;
  logic                          valid_q, valid_d;

  logic [1:0]                    kind_q, kind_d;
  logic                          opart_q, opart_d;
  logic [ilt_pkg::WIDX_W-1:0]    owidx_q, owidx_d;
  logic [ilt_pkg::WORD_W-1:0]    data_q, data_d;
  logic [ilt_pkg::LEN_W-1:0]     nl_q, nl_d;
  logic [ilt_pkg::LEN_W-1:0]     vl_q, vl_d;
  logic [ilt_pkg::LINE_W-1:0]    line_q, line_d;
  logic [2:0]                    code_q, code_d;
  logic                          last_q, last_d;

  logic [ilt_pkg::WCNT_W-1:0]    nw, vw, cur_words;
  logic                          is_rec, word_end, full_rec, final_item, step;
  logic [ilt_pkg::LEN_W-1:0]     cur_len;
  logic [ilt_pkg::WORD_W-1:0]    masked;
  logic [ilt_pkg::ADDR_W-1:0]    pos;

  assign nw        = ilt_pkg::word_count(job_i.name_len);
  assign vw        = ilt_pkg::word_count(job_i.value_len);
  assign is_rec    = (job_i.kind == ilt_pkg::KIND_SECTION) || (job_i.kind == ilt_pkg::KIND_PARAM);
  assign cur_words = part_q ? vw : nw;
  assign cur_len   = part_q ? job_i.value_len : job_i.name_len;
  assign word_end  = ({1'b0, widx_q} == cur_words - ilt_pkg::WCNT_W'(1));
  // A record that fills all result slots of its item leaves no room for the done item.
  assign full_rec  = (job_i.kind == ilt_pkg::KIND_PARAM) &&
                     (nw == ilt_pkg::WCNT_W'(ilt_pkg::STORE_WORDS)) &&
                     (vw == ilt_pkg::WCNT_W'(ilt_pkg::STORE_WORDS));
  assign step      = !q_empty_i && (!valid_q || !out_stall_i);

  assign rd_o.bank = job_i.bank;
  assign rd_o.part = part_q;
  assign rd_o.word = widx_q;

  // Bytes beyond the buffer length are padded with zero.
  always_comb begin
    masked = '0;
    pos    = '0;
    for (int b = 0; b < ilt_pkg::WORD_BYTES; b++) begin
      pos = {widx_q, ilt_pkg::BYTE_SEL_W'(b)};
      if (pos < cur_len) begin
        masked[b*ilt_pkg::CHAR_W +: ilt_pkg::CHAR_W] =
            rd_data_i[b*ilt_pkg::CHAR_W +: ilt_pkg::CHAR_W];
      end
    end
  end

  always_comb begin
    part_d     = part_q;
    widx_d     = widx_q;
    tail_d     = tail_q;
    final_item = 1'b1;
    kind_d     = job_i.kind;
    opart_d    = 1'b0;
    owidx_d    = '0;
    data_d     = '0;
    nl_d       = '0;
    vl_d       = '0;
    line_d     = job_i.line;
    code_d     = '0;
    if (!is_rec) begin
      if (job_i.kind == ilt_pkg::KIND_ERROR) begin
        data_d = {{(ilt_pkg::WORD_W - ilt_pkg::CHAR_W){1'b0}}, job_i.bad_byte};
        code_d = job_i.code;
      end
    end else if (tail_q) begin
      kind_d = ilt_pkg::KIND_DONE;
    end else begin
      opart_d = part_q;
      owidx_d = widx_q;
      data_d  = masked;
      nl_d    = job_i.name_len;
      vl_d    = job_i.value_len;
      if (!word_end) begin
        final_item = 1'b0;
        widx_d     = widx_q + ilt_pkg::WIDX_W'(1);
      end else if (job_i.kind == ilt_pkg::KIND_PARAM && !part_q) begin
        final_item = 1'b0;
        part_d     = 1'b1;
        widx_d     = '0;
      end else if (job_i.with_done && !full_rec) begin
        final_item = 1'b0;
        tail_d     = 1'b1;
      end
    end
    last_d = final_item;
    if (final_item) begin
      part_d = 1'b0;
      widx_d = '0;
      tail_d = 1'b0;
    end
    valid_d = step ? 1'b1 : (valid_q && out_stall_i);
  end

  assign pop_o     = step && final_item;
  assign rel_o.en  = pop_o && is_rec;
  assign rel_o.bank = job_i.bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q  <= 1'b0;
      widx_q  <= '0;
      tail_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (step) begin
        part_q <= part_d;
        widx_q <= widx_d;
        tail_q <= tail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      kind_q  <= kind_d;
      opart_q <= opart_d;
      owidx_q <= owidx_d;
      data_q  <= data_d;
      nl_q    <= nl_d;
      vl_q    <= vl_d;
      line_q  <= line_d;
      code_q  <= code_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign part_o         = opart_q;
  assign word_index_o   = owidx_q;
  assign data_word_o    = data_q;
  assign name_length_o  = nl_q;
  assign value_length_o = vl_q;
  assign line_number_o  = line_q;
  assign error_code_o   = code_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/ini_line_tokenizer.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  char_byte_i, end_of_input_i
// result    out        out_valid_o/out_stall_i kind_o, part_o, word_index_o, data_word_o,
//                                             name_length_o, value_length_o,
//                                             line_number_o, error_code_o, last_o
//
// The parser takes one item per cycle while not stalled; an item that closes a record
// makes the output side send one result per record word (one to eight) plus any done
// item. The output register sends one result per cycle while out_stall_i is low, so
// the sustained rate is set by the word count of each record against its line's bytes.
// Input stalls while the two-entry job queue is full or the name/value bank being
// filled is still being read out. Reset clears all control state at once; the
// byte stores hold no reset value and need no clearing pass.
module ini_line_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    char_byte_i,
  input  logic                          end_of_input_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic                          part_o,
  output logic [1:0]                    word_index_o,
  output logic [63:0]                   data_word_o,
  output logic [4:0]                    name_length_o,
  output logic [4:0]                    value_length_o,
  output logic [19:0]                   line_number_o,
  output logic [2:0]                    error_code_o,
  output logic                          last_o
);

  logic                             push, pop, q_full, q_empty;
  ilt_pkg::job_t                    job_in, job_head;
  ilt_pkg::store_wr_t               store_wr;
  ilt_pkg::store_rd_t               store_rd;
  ilt_pkg::release_t                rel;
  logic [ilt_pkg::WORD_W-1:0]       rd_data;

  ilt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .char_byte_i    (char_byte_i),
    .end_of_input_i (end_of_input_i),
    .in_stall_o     (in_stall_o),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (job_in),
    .wr_o           (store_wr),
    .rel_i          (rel)
  );

  ilt_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_i      (store_rd),
    .rd_data_o (rd_data)
  );

  ilt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ilt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_head),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .rel_o          (rel),
    .rd_o           (store_rd),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .part_o         (part_o),
    .word_index_o   (word_index_o),
    .data_word_o    (data_word_o),
    .name_length_o  (name_length_o),
    .value_length_o (value_length_o),
    .line_number_o  (line_number_o),
    .error_code_o   (error_code_o),
    .last_o         (last_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && kind_o == ilt_pkg::KIND_ERROR) |-> last_o)
    else $error("error result not marked last");

  a_section_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && kind_o == ilt_pkg::KIND_SECTION) |-> (!part_o && value_length_o == '0))
    else $error("section result carries value fields");

endmodule
